FILE: rtl/intake_feeder_sequencer_unit_defines.svh
// assertion helpers used by the sequencer core
`ifndef INTAKE_FEEDER_SEQUENCER_UNIT_DEFINES_SVH
`define INTAKE_FEEDER_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define IFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ifs_pkg.sv
`default_nettype none
package ifs_pkg;

  localparam int ANGLE_W = 13;
  localparam int SPEED_W = 16;
  localparam int TIME_W  = 32;
  localparam int QUOT_W  = ANGLE_W + 1;

  // ramp divisor and fixed roller speeds
  localparam int SPEED_DIV = 16;
  localparam logic signed [SPEED_W-1:0] PUSH_SPEED  = 16'sd16384;
  localparam logic signed [SPEED_W-1:0] SHAKE_SPEED = 16'sd8192;

  // reciprocal for the span divide, exact for any 13-bit magnitude
  localparam int DIV_SHIFT = ANGLE_W + $clog2(SPEED_DIV);
  localparam int DIV_RECIP = (2 ** DIV_SHIFT + SPEED_DIV - 1) / SPEED_DIV;
  localparam int RECIP_W   = ANGLE_W + 2;
  localparam int PROD_W    = ANGLE_W + RECIP_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAKE_ANGLE       = 3'd0,
    REG_LAUNCH_ANGLE     = 3'd1,
    REG_STOP_SHAKE_ANGLE = 3'd2,
    REG_SHAKE_TIME_MS    = 3'd3,
    REG_DOWN_SPEED       = 3'd4,
    REG_UP_MAX_SPEED     = 3'd5,
    REG_UP_INCREMENT     = 3'd6,
    REG_SUCK_SPEED       = 3'd7
  } reg_idx_t;

  typedef enum logic [5:0] {
    M_IDLE   = 6'b000001,
    M_LOWER  = 6'b000010,
    M_INTAKE = 6'b000100,
    M_RAISE  = 6'b001000,
    M_LOADED = 6'b010000,
    M_FIRE   = 6'b100000
  } mode_t;

  localparam logic [2:0] MODE_CODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_CODE_LOWER  = 3'd1;
  localparam logic [2:0] MODE_CODE_INTAKE = 3'd2;
  localparam logic [2:0] MODE_CODE_RAISE  = 3'd3;
  localparam logic [2:0] MODE_CODE_LOADED = 3'd4;
  localparam logic [2:0] MODE_CODE_FIRE   = 3'd5;

  typedef enum logic [1:0] {
    FLAG_NONE    = 2'd0,
    FLAG_PRESENT = 2'd1,
    FLAG_GONE    = 2'd2
  } flag_t;

  typedef enum logic [1:0] {
    LED_GREEN = 2'd0,
    LED_BLUE  = 2'd1,
    LED_RED   = 2'd2
  } led_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        take_angle;
    logic [ANGLE_W-1:0]        launch_angle;
    logic [ANGLE_W-1:0]        stop_shake_angle;
    logic [15:0]               shake_time_ms;
    logic signed [SPEED_W-1:0] down_speed;
    logic [SPEED_W-2:0]        up_max_speed;
    logic [SPEED_W-2:0]        up_increment;
    logic signed [SPEED_W-1:0] suck_speed;
  } cfg_t;

  typedef struct packed {
    logic                      reset_button;
    logic                      start_button;
    logic                      eject_button;
    logic                      trigger_full;
    logic                      ring_switch;
    logic [ANGLE_W-1:0]        arm_angle;
    logic [TIME_W-1:0]         now_ms;
    logic signed [QUOT_W-1:0]  span_q;
  } item_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    unique case (m)
      M_IDLE:   c = MODE_CODE_IDLE;
      M_LOWER:  c = MODE_CODE_LOWER;
      M_INTAKE: c = MODE_CODE_INTAKE;
      M_RAISE:  c = MODE_CODE_RAISE;
      M_LOADED: c = MODE_CODE_LOADED;
      M_FIRE:   c = MODE_CODE_FIRE;
      default:  c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ifs_in_if.sv
`default_nettype none
interface ifs_in_if;
  logic        valid;
  logic        ready;
  logic        reset_button;
  logic        start_button;
  logic        eject_button;
  logic        trigger_full;
  logic        ring_switch;
  logic [12:0] arm_angle;
  logic [31:0] now_ms;

  modport source (
    output valid, reset_button, start_button, eject_button, trigger_full,
           ring_switch, arm_angle, now_ms,
    input  ready
  );
  modport sink (
    input  valid, reset_button, start_button, eject_button, trigger_full,
           ring_switch, arm_angle, now_ms,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/ifs_out_if.sv
`default_nettype none
interface ifs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] arm_command;
  logic signed [15:0] roller_command;
  logic [2:0]         mode;
  logic [1:0]         ring_flag_write;
  logic [1:0]         led_color;

  modport source (
    output valid, arm_command, roller_command, mode, ring_flag_write, led_color,
    input  ready
  );
  modport sink (
    input  valid, arm_command, roller_command, mode, ring_flag_write, led_color,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/ifs_cfg.sv
`default_nettype none
module ifs_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ifs_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [ifs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output ifs_pkg::cfg_t                        cfg
);
  import ifs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_TAKE_ANGLE:       cfg_nxt.take_angle       = cfg_wdata[ANGLE_W-1:0];
        REG_LAUNCH_ANGLE:     cfg_nxt.launch_angle     = cfg_wdata[ANGLE_W-1:0];
        REG_STOP_SHAKE_ANGLE: cfg_nxt.stop_shake_angle = cfg_wdata[ANGLE_W-1:0];
        REG_SHAKE_TIME_MS:    cfg_nxt.shake_time_ms    = cfg_wdata[15:0];
        REG_DOWN_SPEED:       cfg_nxt.down_speed       = $signed(cfg_wdata[SPEED_W-1:0]);
        REG_UP_MAX_SPEED:     cfg_nxt.up_max_speed     = cfg_wdata[SPEED_W-2:0];
        REG_UP_INCREMENT:     cfg_nxt.up_increment     = cfg_wdata[SPEED_W-2:0];
        REG_SUCK_SPEED:       cfg_nxt.suck_speed       = $signed(cfg_wdata[SPEED_W-1:0]);
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: rtl/ifs_span_div.sv
`default_nettype none
module ifs_span_div (
  input  wire logic [ifs_pkg::ANGLE_W-1:0]       take_angle,
  input  wire logic [ifs_pkg::ANGLE_W-1:0]       arm_angle,
  output logic signed [ifs_pkg::QUOT_W-1:0]      span_q
);
  import ifs_pkg::*;

  logic signed [QUOT_W-1:0] diff_w;
  logic                     neg_w;
  logic [ANGLE_W-1:0]       mag_w;
  logic [PROD_W-1:0]        prod_w;
  logic [ANGLE_W-1:0]       qmag_w;

  // remaining span and its magnitude
  assign diff_w = $signed({1'b0, take_angle}) - $signed({1'b0, arm_angle});
  assign neg_w  = diff_w[QUOT_W-1];
  assign mag_w  = neg_w ? ANGLE_W'(-diff_w) : diff_w[ANGLE_W-1:0];

  // divide by reciprocal multiply, truncating toward zero
  assign prod_w = PROD_W'(mag_w) * PROD_W'(DIV_RECIP);
  assign qmag_w = ANGLE_W'(prod_w >> DIV_SHIFT);
  assign span_q = neg_w ? -$signed({1'b0, qmag_w}) : $signed({1'b0, qmag_w});

endmodule
`default_nettype wire

FILE: rtl/ifs_core.sv
`default_nettype none
`include "intake_feeder_sequencer_unit_defines.svh"
module ifs_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire ifs_pkg::cfg_t  cfg,
  input  wire ifs_pkg::item_t itm,
  input  wire logic  itm_vld,
  output logic       itm_rdy,
  ifs_out_if.source  out_ch
);
  import ifs_pkg::*;

  localparam int RAMP_W = QUOT_W + SPEED_W;

  mode_t                     mode_r, mode_nxt;
  logic                      ret_r, ret_nxt;
  logic                      shake_act_r, shake_act_nxt;
  logic                      shake_out_r, shake_out_nxt;
  logic [TIME_W-1:0]         shake_start_r, shake_start_nxt;
  logic signed [SPEED_W-1:0] roller_lvl_r, roller_lvl_nxt;
  logic signed [SPEED_W-1:0] roller_r, roller_nxt;
  logic signed [SPEED_W-1:0] arm_r, arm_nxt;
  led_t                      led_r, led_nxt;
  flag_t                     flag_r, flag_nxt;
  logic                      out_vld_r, out_vld_nxt;

  logic                      adv;
  logic [TIME_W-1:0]         elapsed_w;
  logic                      done_w;
  logic                      above_stop_w;
  logic signed [SPEED_W-1:0] max_s_w;
  logic signed [SPEED_W-1:0] inc_s_w;
  logic signed [RAMP_W-1:0]  ramp_w;
  logic signed [RAMP_W-1:0]  ramp_hi_w;
  logic signed [RAMP_W-1:0]  ramp_clamp_w;
  logic                      run_lower;
  logic                      run_intake;

  assign itm_rdy = !out_vld_r || out_ch.ready;
  assign adv     = itm_vld && itm_rdy;

  // shake timer
  assign elapsed_w    = itm.now_ms - shake_start_r;
  assign done_w       = elapsed_w >= {16'b0, cfg.shake_time_ms};
  assign above_stop_w = itm.arm_angle > cfg.stop_shake_angle;

  // raise ramp with clamps, upper first then lower
  assign max_s_w      = $signed({1'b0, cfg.up_max_speed});
  assign inc_s_w      = $signed({1'b0, cfg.up_increment});
  assign ramp_w       = RAMP_W'(itm.span_q) * RAMP_W'(inc_s_w);
  assign ramp_hi_w    = (ramp_w > RAMP_W'(max_s_w)) ? RAMP_W'(max_s_w) : ramp_w;
  assign ramp_clamp_w = (ramp_hi_w < RAMP_W'(inc_s_w)) ? RAMP_W'(inc_s_w) : ramp_hi_w;

  // mode machine step for one item
  always_comb begin
    mode_nxt        = mode_r;
    ret_nxt         = ret_r;
    shake_act_nxt   = shake_act_r;
    shake_out_nxt   = shake_out_r;
    shake_start_nxt = shake_start_r;
    roller_lvl_nxt  = roller_lvl_r;
    roller_nxt      = roller_r;
    arm_nxt         = arm_r;
    led_nxt         = led_r;
    flag_nxt        = FLAG_NONE;
    run_lower       = 1'b0;
    run_intake      = 1'b0;

    if (itm.reset_button) begin
      ret_nxt  = 1'b1;
      mode_nxt = M_RAISE;
    end

    unique case (mode_nxt)
      M_IDLE: begin
        roller_lvl_nxt = '0;
        roller_nxt     = '0;
        if (itm.ring_switch && shake_act_r) begin
          shake_act_nxt = 1'b0;
        end
        if (itm.ring_switch) begin
          mode_nxt = M_LOADED;
        end
        if (itm.start_button) begin
          mode_nxt  = M_LOWER;
          run_lower = 1'b1;
        end
      end
      M_LOWER: run_lower = 1'b1;
      M_INTAKE: run_intake = 1'b1;
      M_RAISE: begin
        if (shake_act_r) begin
          if (shake_out_r) begin
            // outward phase over: swing back inward
            if (done_w) begin
              shake_out_nxt   = 1'b0;
              shake_start_nxt = itm.now_ms;
              roller_lvl_nxt  = SHAKE_SPEED;
              roller_nxt      = SHAKE_SPEED;
            end
          end else if (itm.ring_switch || done_w) begin
            if (!above_stop_w) begin
              if (itm.ring_switch) begin
                shake_act_nxt  = 1'b0;
                roller_lvl_nxt = '0;
                roller_nxt     = '0;
              end
            end else begin
              shake_act_nxt   = 1'b1;
              shake_out_nxt   = 1'b1;
              shake_start_nxt = itm.now_ms;
              roller_lvl_nxt  = SHAKE_SPEED;
              roller_nxt      = -SHAKE_SPEED;
            end
          end
        end else if (above_stop_w) begin
          shake_act_nxt   = 1'b1;
          shake_out_nxt   = 1'b1;
          shake_start_nxt = itm.now_ms;
          roller_lvl_nxt  = SHAKE_SPEED;
          roller_nxt      = -SHAKE_SPEED;
        end

        if (itm.arm_angle <= cfg.launch_angle) begin
          arm_nxt = '0;
          if (ret_nxt) begin
            ret_nxt  = 1'b0;
            mode_nxt = M_IDLE;
          end else begin
            mode_nxt = M_LOADED;
          end
        end else if (arm_r < max_s_w) begin
          arm_nxt = SPEED_W'(ramp_clamp_w);
        end
      end
      M_LOADED: begin
        if (itm.ring_switch && (roller_lvl_r != '0 || shake_act_r)) begin
          shake_act_nxt  = 1'b0;
          roller_lvl_nxt = '0;
          roller_nxt     = '0;
        end
        if (itm.trigger_full) begin
          roller_lvl_nxt = PUSH_SPEED;
          roller_nxt     = PUSH_SPEED;
          mode_nxt       = M_FIRE;
        end
      end
      M_FIRE: begin
        if (!itm.trigger_full) begin
          flag_nxt       = FLAG_GONE;
          roller_lvl_nxt = '0;
          roller_nxt     = '0;
          mode_nxt       = M_IDLE;
        end
      end
      default: begin
      end
    endcase

    // lowering, chains into intake once the take angle is reached
    if (run_lower) begin
      if (itm.arm_angle < cfg.take_angle) begin
        arm_nxt = cfg.down_speed;
      end else begin
        arm_nxt    = '0;
        mode_nxt   = M_INTAKE;
        run_intake = 1'b1;
      end
    end

    // intake roller, ring arrival starts the raise
    if (run_intake) begin
      if (itm.eject_button) begin
        roller_lvl_nxt = PUSH_SPEED;
        roller_nxt     = PUSH_SPEED;
      end else begin
        if (roller_lvl_nxt != cfg.suck_speed) begin
          roller_lvl_nxt = cfg.suck_speed;
          roller_nxt     = cfg.suck_speed;
        end
        if (itm.ring_switch) begin
          flag_nxt       = FLAG_PRESENT;
          roller_lvl_nxt = '0;
          roller_nxt     = '0;
          mode_nxt       = M_RAISE;
        end
      end
    end

    // led follows the new mode, fire keeps the last color
    priority if (mode_nxt == M_LOADED) begin
      led_nxt = LED_GREEN;
    end else if (mode_nxt == M_INTAKE) begin
      led_nxt = LED_BLUE;
    end else if (mode_nxt == M_IDLE || mode_nxt == M_LOWER || mode_nxt == M_RAISE) begin
      led_nxt = LED_RED;
    end else begin
      led_nxt = led_r;
    end
  end

  assign out_vld_nxt = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);

  // sequencer state, doubles as the held result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= M_IDLE;
      ret_r         <= 1'b0;
      shake_act_r   <= 1'b1;
      shake_out_r   <= 1'b0;
      shake_start_r <= '0;
      roller_lvl_r  <= '0;
      roller_r      <= '0;
      arm_r         <= '0;
      led_r         <= LED_RED;
      out_vld_r     <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        mode_r        <= mode_nxt;
        ret_r         <= ret_nxt;
        shake_act_r   <= shake_act_nxt;
        shake_out_r   <= shake_out_nxt;
        shake_start_r <= shake_start_nxt;
        roller_lvl_r  <= roller_lvl_nxt;
        roller_r      <= roller_nxt;
        arm_r         <= arm_nxt;
        led_r         <= led_nxt;
      end
    end
  end

  // ring flag of the item on the output
  always_ff @(posedge clk) begin
    if (adv) begin
      flag_r <= flag_nxt;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.arm_command     = arm_r;
  assign out_ch.roller_command  = roller_r;
  assign out_ch.mode            = mode_code(mode_r);
  assign out_ch.ring_flag_write = flag_r;
  assign out_ch.led_color       = led_r;

  `IFS_ASSERT_IMP(a_flag_present, out_vld_r && flag_r == FLAG_PRESENT, mode_r == M_RAISE, "ring present published outside raise")
  `IFS_ASSERT_IMP(a_flag_gone, out_vld_r && flag_r == FLAG_GONE, mode_r == M_IDLE, "ring gone published outside idle")
  `IFS_ASSERT_IMP(a_led_loaded, mode_r == M_LOADED, led_r == LED_GREEN, "loaded without green led")
  `IFS_ASSERT_IMP(a_return_raise, ret_r, mode_r == M_RAISE, "return to idle pending outside raise")
  `IFS_ASSERT_NXT(a_adv_valid, adv, out_vld_r, "stepped item did not reach the output")

endmodule
`default_nettype wire

FILE: rtl/intake_feeder_sequencer_unit.sv
// a result is valid after its item passes the input register, then the mode step
// one item per cycle unless the output stalls; the mode step closes the state loop
// a stalled output holds its result while one more item waits in the input register
// reset (synchronous, rst_n low): mode idle, led red, shake armed, motor commands zero,
// all configuration registers zero, both channels empty
`default_nettype none
module intake_feeder_sequencer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ifs_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [ifs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  ifs_in_if.sink                               in_ch,
  ifs_out_if.source                            out_ch
);
  import ifs_pkg::*;

  cfg_t                     cfg;
  item_t                    item_w;
  item_t                    item_r;
  logic                     in_vld_r, in_vld_nxt;
  logic                     core_rdy;
  logic                     in_acc;
  logic signed [QUOT_W-1:0] span_q_w;

  ifs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // ramp span quotient, taken with the item
  ifs_span_div u_div (
    .take_angle (cfg.take_angle),
    .arm_angle  (in_ch.arm_angle),
    .span_q     (span_q_w)
  );

  assign item_w = '{
    reset_button: in_ch.reset_button,
    start_button: in_ch.start_button,
    eject_button: in_ch.eject_button,
    trigger_full: in_ch.trigger_full,
    ring_switch:  in_ch.ring_switch,
    arm_angle:    in_ch.arm_angle,
    now_ms:       in_ch.now_ms,
    span_q:       span_q_w
  };

  // input register
  assign in_ch.ready = !in_vld_r || core_rdy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_vld_nxt  = in_acc ? 1'b1 : (core_rdy ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= item_w;
    end
  end

  ifs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .itm     (item_r),
    .itm_vld (in_vld_r),
    .itm_rdy (core_rdy),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

FILE: dv/tb_intake_feeder_sequencer_unit.sv
`timescale 1ns / 1ps
module tb_intake_feeder_sequencer_unit;
  import ifs_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int PHASE_ITEMS    = 200;
  localparam int RANDOM_PHASES  = 8;
  localparam int PAUSE_PHASE    = 4;
  localparam int MAX_REPORTS    = 40;
  localparam int ANGLE_TOP      = 8191;

  // one control tick as driven on the input channel
  typedef struct packed {
    logic        rst_btn;
    logic        start_btn;
    logic        eject_btn;
    logic        trig;
    logic        ring;
    logic [12:0] angle;
    logic [31:0] now;
  } tick_t;

  localparam int TICK_W = $bits(tick_t);

  // motor commands and status for one tick
  typedef struct packed {
    logic signed [15:0] arm;
    logic signed [15:0] roller;
    logic [2:0]         mode;
    flag_t              flag;
    led_t               led;
  } cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ifs_in_if  in_ch ();
  ifs_out_if out_ch ();

  intake_feeder_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  // sequencer shadow: settings and state
  cfg_t               shadow;
  logic [2:0]         seq_mode;
  bit                 back_to_idle;
  bit                 shaking;
  bit                 shake_out;
  logic [31:0]        shake_t0;
  logic signed [15:0] roller_lvl;
  logic signed [15:0] roller_cmd;
  logic signed [15:0] arm_cmd;
  led_t               led_now;
  flag_t              flag_now;

  tick_t tick_backlog[$];
  cmd_t  cmd_backlog[$];
  tick_t tick_on_bus;

  int          ticks_queued = 0;
  int          ticks_taken = 0;
  int          cmds_checked = 0;
  int          err_count = 0;
  int          settings_used = 0;
  int          quiet_cycles = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          in_steady = 1'b0;
  bit          out_steady = 1'b0;
  int          mode_seen[6];
  int          gen_angle = 0;
  logic [31:0] gen_now = '0;
  int          tick_ms_max = 4;

  function automatic void reset_shadow();
    shadow       = '0;
    seq_mode     = MODE_CODE_IDLE;
    back_to_idle = 1'b0;
    shaking      = 1'b1;
    shake_out    = 1'b0;
    shake_t0     = '0;
    roller_lvl   = '0;
    roller_cmd   = '0;
    arm_cmd      = '0;
    led_now      = LED_RED;
    flag_now     = FLAG_NONE;
  endfunction

  function automatic void roller_set(logic signed [15:0] lvl, logic signed [15:0] cmd);
    roller_lvl = lvl;
    roller_cmd = cmd;
  endfunction

  // a ring at the switch ends any shaking
  function automatic void shake_halt(bit ring);
    if (ring && (roller_lvl != 0 || shaking)) begin
      shaking = 1'b0;
      roller_set(16'sd0, 16'sd0);
    end
  endfunction

  // outward shake phase, only above the stop angle
  function automatic void shake_kick(logic [12:0] angle, logic [31:0] now);
    if (angle > shadow.stop_shake_angle) begin
      shaking   = 1'b1;
      shake_out = 1'b1;
      shake_t0  = now;
      roller_set(SHAKE_SPEED, -SHAKE_SPEED);
    end
  endfunction

  function automatic void shake_tick(bit ring, logic [12:0] angle, logic [31:0] now);
    logic [31:0] elapsed;
    bit          done;
    elapsed = now - shake_t0;
    done    = elapsed >= {16'd0, shadow.shake_time_ms};
    if (shake_out) begin
      if (done) begin
        shake_out = 1'b0;
        shake_t0  = now;
        roller_set(SHAKE_SPEED, SHAKE_SPEED);
      end
    end else if (ring || done) begin
      if (angle <= shadow.stop_shake_angle) shake_halt(ring);
      else shake_kick(angle, now);
    end
  endfunction

  function automatic void intake_tick(bit eject, bit ring);
    if (eject) begin
      roller_set(PUSH_SPEED, PUSH_SPEED);
    end else begin
      if (roller_lvl != shadow.suck_speed) roller_set(shadow.suck_speed, shadow.suck_speed);
      if (ring) begin
        flag_now = FLAG_PRESENT;
        roller_set(16'sd0, 16'sd0);
        seq_mode = MODE_CODE_RAISE;
      end
    end
  endfunction

  function automatic void lower_tick(bit eject, bit ring, logic [12:0] angle);
    if (angle < shadow.take_angle) begin
      arm_cmd = shadow.down_speed;
    end else begin
      arm_cmd  = 16'sd0;
      seq_mode = MODE_CODE_INTAKE;
      intake_tick(eject, ring);
    end
  endfunction

  function automatic void raise_tick(bit ring, logic [12:0] angle, logic [31:0] now);
    int     span;
    int     quot;
    longint ramp;
    if (shaking) shake_tick(ring, angle, now);
    else shake_kick(angle, now);
    if (angle <= shadow.launch_angle) begin
      arm_cmd = 16'sd0;
      if (back_to_idle) begin
        back_to_idle = 1'b0;
        seq_mode     = MODE_CODE_IDLE;
      end else begin
        seq_mode = MODE_CODE_LOADED;
      end
    end else if (int'(arm_cmd) < int'(shadow.up_max_speed)) begin
      // ramp on the remaining span, quotient truncated toward zero
      span = int'(shadow.take_angle) - int'(angle);
      quot = span / SPEED_DIV;
      ramp = longint'(quot) * longint'(shadow.up_increment);
      if (ramp > longint'(shadow.up_max_speed)) ramp = longint'(shadow.up_max_speed);
      if (ramp < longint'(shadow.up_increment)) ramp = longint'(shadow.up_increment);
      arm_cmd = 16'(ramp);
    end
  endfunction

  // advance the shadow by one accepted tick
  function automatic cmd_t step_sequencer(tick_t t);
    cmd_t r;
    flag_now = FLAG_NONE;
    if (t.rst_btn) begin
      back_to_idle = 1'b1;
      seq_mode     = MODE_CODE_RAISE;
    end
    case (seq_mode)
      MODE_CODE_IDLE: begin
        roller_set(16'sd0, 16'sd0);
        shake_halt(t.ring);
        if (t.ring) seq_mode = MODE_CODE_LOADED;
        if (t.start_btn) begin
          seq_mode = MODE_CODE_LOWER;
          lower_tick(t.eject_btn, t.ring, t.angle);
        end
      end
      MODE_CODE_LOWER:  lower_tick(t.eject_btn, t.ring, t.angle);
      MODE_CODE_INTAKE: intake_tick(t.eject_btn, t.ring);
      MODE_CODE_RAISE:  raise_tick(t.ring, t.angle, t.now);
      MODE_CODE_LOADED: begin
        shake_halt(t.ring);
        if (t.trig) begin
          roller_set(PUSH_SPEED, PUSH_SPEED);
          seq_mode = MODE_CODE_FIRE;
        end
      end
      MODE_CODE_FIRE: begin
        if (!t.trig) begin
          flag_now = FLAG_GONE;
          roller_set(16'sd0, 16'sd0);
          seq_mode = MODE_CODE_IDLE;
        end
      end
      default: ;
    endcase
    // led holds its color in fire
    if (seq_mode == MODE_CODE_LOADED) led_now = LED_GREEN;
    else if (seq_mode == MODE_CODE_INTAKE) led_now = LED_BLUE;
    else if (seq_mode == MODE_CODE_IDLE || seq_mode == MODE_CODE_LOWER ||
             seq_mode == MODE_CODE_RAISE) led_now = LED_RED;
    r.arm    = arm_cmd;
    r.roller = roller_cmd;
    r.mode   = seq_mode;
    r.flag   = flag_now;
    r.led    = led_now;
    return r;
  endfunction

  function automatic tick_t make_tick(bit rst, bit start, bit eject, bit trig, bit ring,
                                      int angle, logic [31:0] now);
    tick_t t;
    t.rst_btn   = rst;
    t.start_btn = start;
    t.eject_btn = eject;
    t.trig      = trig;
    t.ring      = ring;
    t.angle     = 13'(angle);
    t.now       = now;
    return t;
  endfunction

  // queue a tick at the current arm angle, advancing the millisecond clock
  function automatic void push_tick(bit rst, bit start, bit eject, bit trig, bit ring);
    tick_t t;
    if ($urandom_range(0, 15) == 0) gen_now += $urandom;
    else gen_now += $urandom_range(0, tick_ms_max);
    t = make_tick(rst, start, eject, trig, ring, gen_angle, gen_now);
    // rare stray button press
    if ($urandom_range(0, 39) == 0) t[TICK_W - 1 - int'($urandom_range(0, 4))] ^= 1'b1;
    tick_backlog.push_back(t);
    ticks_queued++;
  endfunction

  function automatic void push_noise();
    tick_backlog.push_back(make_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), $urandom_range(0, ANGLE_TOP),
                                     $urandom));
    ticks_queued++;
  endfunction

  // arm swings up to a little past the launch angle
  function automatic void raise_ticks();
    int lo;
    int target;
    int k;
    lo     = gen_angle;
    target = int'(shadow.launch_angle) - int'($urandom_range(0, 20));
    if (target < 0) target = 0;
    k = $urandom_range(2, 12);
    for (int i = 1; i <= k; i++) begin
      gen_angle = lo + (target - lo) * i / k;
      push_tick(1'b0, 1'b0, 1'b0, 1'b0, $urandom_range(0, 3) != 0);
    end
  endfunction

  // full pickup and shot, sometimes cut short by the reset button
  function automatic void ring_cycle();
    int abort_at;
    int lo;
    int target;
    int k;
    abort_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
    repeat ($urandom_range(0, 2)) push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0, 1'b0, $urandom_range(0, 7) == 0);
    // lowering toward the pickup angle
    lo     = gen_angle;
    target = int'(shadow.take_angle) + int'($urandom_range(0, 20));
    if (target > ANGLE_TOP) target = ANGLE_TOP;
    k = $urandom_range(1, 6);
    for (int i = 1; i <= k; i++) begin
      gen_angle = lo + (target - lo) * i / k;
      push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    end
    if (abort_at != 1) begin
      // intake, then the ring arrives
      repeat ($urandom_range(0, 4)) push_tick(1'b0, 1'b0, $urandom_range(0, 3) == 0, 1'b0, 1'b0);
      push_tick(1'b0, 1'b0, $urandom_range(0, 5) == 0, 1'b0, 1'b1);
      if ($urandom_range(0, 1) != 0) push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      if (abort_at != 2) begin
        raise_ticks();
        if (abort_at != 3) begin
          repeat ($urandom_range(0, 3)) push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
          repeat ($urandom_range(1, 3)) push_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
          if (abort_at != 4) begin
            push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
            return;
          end
        end
      end
    end
    // reset button sends the arm back up to idle
    push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
    raise_ticks();
  endfunction

  function automatic cfg_t pick_settings(int kind);
    cfg_t c;
    int   top;
    c = '0;
    case (kind)
      0: begin
        c.down_speed = 16'sh8000;
        c.suck_speed = 16'sh8000;
      end
      1: begin
        c.take_angle       = 13'd5759;
        c.launch_angle     = 13'd5759;
        c.stop_shake_angle = 13'd5759;
        c.shake_time_ms    = 16'hFFFF;
        c.down_speed       = 16'sh7FFF;
        c.up_max_speed     = 15'h7FFF;
        c.up_increment     = 15'h7FFF;
        c.suck_speed       = 16'sh7FFF;
      end
      default: begin
        c.launch_angle     = 13'($urandom_range(0, 1500));
        c.stop_shake_angle = 13'(int'(c.launch_angle) + $urandom_range(0, 1500));
        c.take_angle       = 13'(int'(c.stop_shake_angle) + $urandom_range(0, 2700));
        c.shake_time_ms    = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                                          16'($urandom_range(0, 60));
        c.down_speed       = 16'($urandom);
        c.suck_speed       = 16'($urandom);
        top                = $urandom_range(0, 32767);
        c.up_max_speed     = 15'(top);
        // setting kind 2 inverts the clamps: increment above the maximum
        if (kind == 2) c.up_increment = 15'(top + $urandom_range(1, 32767 - top + 1));
        else c.up_increment = 15'($urandom_range(0, 4000));
        if (kind == 2 && top == 32767) c.up_max_speed = 15'd1000;
      end
    endcase
    return c;
  endfunction

  task automatic cfg_write(input reg_idx_t idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_TAKE_ANGLE:       shadow.take_angle = data[12:0];
      REG_LAUNCH_ANGLE:     shadow.launch_angle = data[12:0];
      REG_STOP_SHAKE_ANGLE: shadow.stop_shake_angle = data[12:0];
      REG_SHAKE_TIME_MS:    shadow.shake_time_ms = data;
      REG_DOWN_SPEED:       shadow.down_speed = data;
      REG_UP_MAX_SPEED:     shadow.up_max_speed = data[14:0];
      REG_UP_INCREMENT:     shadow.up_increment = data[14:0];
      REG_SUCK_SPEED:       shadow.suck_speed = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_settings(input cfg_t c);
    cfg_write(REG_TAKE_ANGLE, 16'(c.take_angle));
    cfg_write(REG_LAUNCH_ANGLE, 16'(c.launch_angle));
    cfg_write(REG_STOP_SHAKE_ANGLE, 16'(c.stop_shake_angle));
    cfg_write(REG_SHAKE_TIME_MS, c.shake_time_ms);
    cfg_write(REG_DOWN_SPEED, c.down_speed);
    cfg_write(REG_UP_MAX_SPEED, 16'(c.up_max_speed));
    cfg_write(REG_UP_INCREMENT, 16'(c.up_increment));
    cfg_write(REG_SUCK_SPEED, c.suck_speed);
    settings_used++;
    // clock steps sized so shake phases expire within a raise
    if (c.shake_time_ms == 0) tick_ms_max = 4;
    else if (c.shake_time_ms > 2000) tick_ms_max = 1000;
    else tick_ms_max = (int'(c.shake_time_ms) + 1) / 2;
  endtask

  // sampled at the falling edge so all drives have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (tick_backlog.size() != 0 || in_ch.valid || cmd_backlog.size() != 0);
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", cmds_checked, name, got, want));
  endtask

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cmd_backlog.push_back(step_sequencer(tick_on_bus));
        ticks_taken++;
        if (ticks_taken % 100 == 0) in_steady = ($urandom_range(0, 3) == 0);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (tick_backlog.size() != 0) begin
          tick_on_bus = tick_backlog.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.reset_button <= tick_on_bus.rst_btn;
          in_ch.start_button <= tick_on_bus.start_btn;
          in_ch.eject_button <= tick_on_bus.eject_btn;
          in_ch.trigger_full <= tick_on_bus.trig;
          in_ch.ring_switch  <= tick_on_bus.ring;
          in_ch.arm_angle    <= tick_on_bus.angle;
          in_ch.now_ms       <= tick_on_bus.now;
          in_gap = in_steady ? 0 : $urandom_range(0, 5);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    cmd_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (cmd_backlog.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", cmds_checked));
        end else begin
          want = cmd_backlog.pop_front();
          check_field("arm_command", out_ch.arm_command, want.arm);
          check_field("roller_command", out_ch.roller_command, want.roller);
          check_field("mode", 16'(out_ch.mode), 16'(want.mode));
          check_field("ring_flag_write", 16'(out_ch.ring_flag_write), 16'(want.flag));
          check_field("led_color", 16'(out_ch.led_color), 16'(want.led));
        end
        if (out_ch.mode <= MODE_CODE_FIRE) mode_seen[out_ch.mode]++;
        cmds_checked++;
        if (cmds_checked % 100 == 0) out_steady = ($urandom_range(0, 3) == 0);
        out_gap = out_steady ? 0 : $urandom_range(0, 5);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake and no register write
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t c;
    int   phase_base;
    bit   paused;
    in_ch.valid        = 1'b0;
    in_ch.reset_button = 1'b0;
    in_ch.start_button = 1'b0;
    in_ch.eject_button = 1'b0;
    in_ch.trigger_full = 1'b0;
    in_ch.ring_switch  = 1'b0;
    in_ch.arm_angle    = '0;
    in_ch.now_ms       = '0;
    out_ch.ready       = 1'b0;
    paused             = 1'b0;
    foreach (mode_seen[m]) mode_seen[m] = 0;
    reset_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk through every mode and the corner cases
    c.take_angle       = 13'd2000;
    c.launch_angle     = 13'd200;
    c.stop_shake_angle = 13'd800;
    c.shake_time_ms    = 16'd10;
    c.down_speed       = -16'sd12000;
    c.up_max_speed     = 15'd20000;
    c.up_increment     = 15'd1500;
    c.suck_speed       = -16'sd20000;
    program_settings(c);
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 0, 0, 0));
    // start wins over a ring sitting in idle
    tick_backlog.push_back(make_tick(0, 1, 0, 0, 1, 0, 1));
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 0, 1000, 2));
    tick_backlog.push_back(make_tick(0, 0, 1, 0, 0, 2000, 3));
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 0, 2000, 4));
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 1, 2000, 5));
    // raise above the pickup angle: negative ramp clamps to the increment
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 1, 5759, 100));
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 1, 1900, 105));
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 0, 1500, 110));
    // shake timer across the 32-bit wrap
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 0, 1000, 32'hFFFF_FFF0));
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 0, 900, 32'h0000_0005));
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 1, 700, 6));
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 1, 200, 7));
    tick_backlog.push_back(make_tick(0, 0, 0, 1, 1, 200, 8));
    tick_backlog.push_back(make_tick(0, 0, 0, 1, 1, 200, 9));
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 0, 200, 10));
    // chained idle to lower to intake at an out of range angle
    tick_backlog.push_back(make_tick(0, 1, 0, 0, 1, ANGLE_TOP, 11));
    tick_backlog.push_back(make_tick(1, 0, 0, 0, 0, ANGLE_TOP, 12));
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 0, 0, 13));
    tick_backlog.push_back(make_tick(0, 0, 0, 0, 1, 4096, 14));
    tick_backlog.push_back(make_tick(1, 0, 1, 1, 1, ANGLE_TOP, 32'hFFFF_FFFF));
    tick_backlog.push_back(make_tick(0, 1, 1, 1, 1, 100, 0));
    ticks_queued += tick_backlog.size();
    wait_drained();

    // random pickup cycles under several register settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_settings(pick_settings(phase));
      phase_base = ticks_queued;
      while (ticks_queued - phase_base < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) push_noise();
        else ring_cycle();
        // hold the sender once until every result is back
        if (phase == PAUSE_PHASE && !paused && ticks_queued - phase_base >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (cmd_backlog.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", cmd_backlog.size()));
    $display("covered %0d items under %0d register settings, %0d results checked",
             ticks_taken, settings_used, cmds_checked);
    $display("results by mode idle %0d lower %0d intake %0d raise %0d loaded %0d fire %0d",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4], mode_seen[5]);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ifs_pkg.sv
rtl/ifs_in_if.sv
rtl/ifs_out_if.sv
rtl/ifs_cfg.sv
rtl/ifs_span_div.sv
rtl/ifs_core.sv
rtl/intake_feeder_sequencer_unit.sv
dv/tb_intake_feeder_sequencer_unit.sv
